/* src/csob_pkg.sv */
package csob_pkg;

    localparam int CovW   = 17;
    localparam int PixW   = 32;
    localparam int CfgIdxW = 3;

    localparam logic [CovW-1:0] ONE_Q16      = 17'd65536;
    localparam logic [CovW-1:0] FULL_COV_MIN = 17'd65471;

    typedef enum logic [CfgIdxW-1:0] {
        REG_COLOR_RED   = 3'd0,
        REG_COLOR_GREEN = 3'd1,
        REG_COLOR_BLUE  = 3'd2,
        REG_COLOR_ALPHA = 3'd3,
        REG_MASK_ENABLE = 3'd4
    } cfg_reg_t;

    // saturated register view
    typedef struct packed {
        logic [CovW-1:0] red;
        logic [CovW-1:0] green;
        logic [CovW-1:0] blue;
        logic [CovW-1:0] alpha;
        logic            mask_enable;
    } cfg_t;

    // premultiplied, coverage-scaled source for one pixel
    typedef struct packed {
        logic            valid;
        logic            write;
        logic [7:0]      sr;
        logic [7:0]      sg;
        logic [7:0]      sb;
        logic [7:0]      sa;
        logic [PixW-1:0] dst;
    } src_t;

    function automatic logic [CovW-1:0] sat_one(input logic [CovW-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    // round(v * 255 / 2^16)
    function automatic logic [7:0] to_u8_q16(input logic [16:0] v);
        logic [25:0] t;
        t = {1'b0, v, 8'd0} - {9'd0, v} + (26'd1 << 15);
        return (t[25:16] > 10'd255) ? 8'hff : t[23:16];
    endfunction

    // round(v * 255 / 2^32)
    function automatic logic [7:0] to_u8_q32(input logic [32:0] v);
        logic [41:0] t;
        t = {1'b0, v, 8'd0} - {9'd0, v} + (42'd1 << 31);
        return (t[41:32] > 10'd255) ? 8'hff : t[39:32];
    endfunction

    // round(v * 255 / 2^48)
    function automatic logic [7:0] to_u8_q48(input logic [48:0] v);
        logic [57:0] t;
        t = {1'b0, v, 8'd0} - {9'd0, v} + (58'd1 << 47);
        return (t[57:48] > 10'd255) ? 8'hff : t[55:48];
    endfunction

    // s + round(d * inv / 255) from m = d * inv + 127, saturated
    function automatic logic [7:0] over_finish(input logic [7:0] s, input logic [15:0] m);
        logic [16:0] t;
        logic [7:0]  q;
        logic [8:0]  v;
        t = {1'b0, m} + {9'd0, m[15:8]} + 17'd1;
        q = t[15:8];
        v = {1'b0, s} + {1'b0, q};
        return v[8] ? 8'hff : v[7:0];
    endfunction

endpackage

/* src/csob_cfg.sv */
module csob_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [csob_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [csob_pkg::CovW-1:0]     cfg_data,
    output csob_pkg::cfg_t                cfg
);
    import csob_pkg::*;

    logic [CovW-1:0] red_reg,   red_next;
    logic [CovW-1:0] green_reg, green_next;
    logic [CovW-1:0] blue_reg,  blue_next;
    logic [CovW-1:0] alpha_reg, alpha_next;
    logic            mask_en_reg, mask_en_next;

    always_comb
    begin
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        alpha_next   = alpha_reg;
        mask_en_next = mask_en_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COLOR_RED:   red_next     = cfg_data;
                REG_COLOR_GREEN: green_next   = cfg_data;
                REG_COLOR_BLUE:  blue_next    = cfg_data;
                REG_COLOR_ALPHA: alpha_next   = cfg_data;
                REG_MASK_ENABLE: mask_en_next = cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg     <= '0;
            green_reg   <= '0;
            blue_reg    <= '0;
            alpha_reg   <= ONE_Q16;
            mask_en_reg <= 1'b0;
        end
        else
        begin
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            alpha_reg   <= alpha_next;
            mask_en_reg <= mask_en_next;
        end
    end

    assign cfg.red         = sat_one(red_reg);
    assign cfg.green       = sat_one(green_reg);
    assign cfg.blue        = sat_one(blue_reg);
    assign cfg.alpha       = sat_one(alpha_reg);
    assign cfg.mask_enable = mask_en_reg;

endmodule

/* src/csob_src.sv */
module csob_src (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [csob_pkg::CovW-1:0]  coverage,
    input  logic [csob_pkg::CovW-1:0]  mask_sample,
    input  logic [csob_pkg::PixW-1:0]  dst_pixel,
    input  csob_pkg::cfg_t             cfg,
    output csob_pkg::src_t             src
);
    import csob_pkg::*;

    // stage 0: input capture with clamp
    logic            v0_reg;
    logic [CovW-1:0] cov0_reg, cov0_next;
    logic [CovW-1:0] mask0_reg, mask0_next;
    logic [PixW-1:0] dst0_reg;

    // stage 1: masked coverage
    logic            v1_reg;
    logic [CovW-1:0] cov1_reg, cov1_next;
    logic [PixW-1:0] dst1_reg;
    logic [32:0]     mprod;

    // stage 2: alpha * coverage, color * alpha
    logic            v2_reg;
    logic            skip2_reg, skip2_next;
    logic [CovW-1:0] cov2_reg;
    logic [32:0]     pa2_reg, pa2_next;
    logic [32:0]     pr2_reg, pr2_next;
    logic [32:0]     pg2_reg, pg2_next;
    logic [32:0]     pb2_reg, pb2_next;
    logic [PixW-1:0] dst2_reg;

    // stage 3: color * alpha * coverage, 8-bit roundings
    logic            v3_reg;
    logic            skip3_reg, skip3_next;
    logic            full3_reg, full3_next;
    logic [7:0]      sa3_reg, sa3_next;
    logic [7:0]      fr3_reg, fr3_next;
    logic [7:0]      fg3_reg, fg3_next;
    logic [7:0]      fb3_reg, fb3_next;
    logic [48:0]     qr3_reg, qr3_next;
    logic [48:0]     qg3_reg, qg3_next;
    logic [48:0]     qb3_reg, qb3_next;
    logic [PixW-1:0] dst3_reg;
    logic [49:0]     qr_full, qg_full, qb_full;

    // stage 4: source select
    src_t            src_reg, src_next;

    always_comb
    begin
        cov0_next  = sat_one(coverage);
        mask0_next = sat_one(mask_sample);

        mprod = {16'd0, cov0_reg} * {16'd0, mask0_reg} + 33'd32768;
        cov1_next = cfg.mask_enable ? mprod[32:16] : cov0_reg;

        skip2_next = (cov1_reg == '0);
        pa2_next   = {16'd0, cfg.alpha} * {16'd0, cov1_reg};
        pr2_next   = {16'd0, cfg.red}   * {16'd0, cfg.alpha};
        pg2_next   = {16'd0, cfg.green} * {16'd0, cfg.alpha};
        pb2_next   = {16'd0, cfg.blue}  * {16'd0, cfg.alpha};

        sa3_next   = to_u8_q32(pa2_reg);
        skip3_next = skip2_reg || (sa3_next == 8'd0);
        full3_next = (cov2_reg >= FULL_COV_MIN);
        fr3_next   = to_u8_q32(pr2_reg);
        fg3_next   = to_u8_q32(pg2_reg);
        fb3_next   = to_u8_q32(pb2_reg);
        qr_full    = {17'd0, pr2_reg} * {33'd0, cov2_reg};
        qg_full    = {17'd0, pg2_reg} * {33'd0, cov2_reg};
        qb_full    = {17'd0, pb2_reg} * {33'd0, cov2_reg};
        qr3_next   = qr_full[48:0];
        qg3_next   = qg_full[48:0];
        qb3_next   = qb_full[48:0];

        src_next.valid = v3_reg;
        src_next.write = !skip3_reg;
        src_next.dst   = dst3_reg;
        if (full3_reg)
        begin
            src_next.sr = fr3_reg;
            src_next.sg = fg3_reg;
            src_next.sb = fb3_reg;
            src_next.sa = to_u8_q16(cfg.alpha);
        end
        else
        begin
            src_next.sr = to_u8_q48(qr3_reg);
            src_next.sg = to_u8_q48(qg3_reg);
            src_next.sb = to_u8_q48(qb3_reg);
            src_next.sa = sa3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            src_reg <= '0;
        end
        else
        begin
            v0_reg  <= in_valid;
            v1_reg  <= v0_reg;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            src_reg <= src_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cov0_reg  <= cov0_next;
        mask0_reg <= mask0_next;
        dst0_reg  <= dst_pixel;

        cov1_reg  <= cov1_next;
        dst1_reg  <= dst0_reg;

        skip2_reg <= skip2_next;
        cov2_reg  <= cov1_reg;
        pa2_reg   <= pa2_next;
        pr2_reg   <= pr2_next;
        pg2_reg   <= pg2_next;
        pb2_reg   <= pb2_next;
        dst2_reg  <= dst1_reg;

        skip3_reg <= skip3_next;
        full3_reg <= full3_next;
        sa3_reg   <= sa3_next;
        fr3_reg   <= fr3_next;
        fg3_reg   <= fg3_next;
        fb3_reg   <= fb3_next;
        qr3_reg   <= qr3_next;
        qg3_reg   <= qg3_next;
        qb3_reg   <= qb3_next;
        dst3_reg  <= dst2_reg;
    end

    assign src = src_reg;

endmodule

/* src/csob_over.sv */
module csob_over (
    input  logic                       clk,
    input  logic                       rst_n,
    input  csob_pkg::src_t             src,
    output logic                       done,
    output logic [csob_pkg::PixW-1:0]  pixel_out,
    output logic                       written
);
    import csob_pkg::*;

    // stage 5: destination * (255 - alpha) + 127
    logic            v5_reg;
    logic            write5_reg;
    logic [7:0]      sr5_reg, sg5_reg, sb5_reg;
    logic [15:0]     mr5_reg, mr5_next;
    logic [15:0]     mg5_reg, mg5_next;
    logic [15:0]     mb5_reg, mb5_next;
    logic [PixW-1:0] dst5_reg;
    logic [7:0]      inv;

    // stage 6: divide by 255, add, saturate
    logic            done_reg;
    logic            written_reg, written_next;
    logic [PixW-1:0] pixel_reg, pixel_next;

    always_comb
    begin
        inv      = 8'd255 - src.sa;
        mr5_next = {8'd0, src.dst[23:16]} * {8'd0, inv} + 16'd127;
        mg5_next = {8'd0, src.dst[15:8]}  * {8'd0, inv} + 16'd127;
        mb5_next = {8'd0, src.dst[7:0]}   * {8'd0, inv} + 16'd127;

        written_next = write5_reg;
        if (write5_reg)
        begin
            pixel_next = {8'hff, over_finish(sr5_reg, mr5_reg),
                          over_finish(sg5_reg, mg5_reg), over_finish(sb5_reg, mb5_reg)};
        end
        else
        begin
            pixel_next = dst5_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v5_reg   <= src.valid;
            done_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        write5_reg  <= src.write;
        sr5_reg     <= src.sr;
        sg5_reg     <= src.sg;
        sb5_reg     <= src.sb;
        mr5_reg     <= mr5_next;
        mg5_reg     <= mg5_next;
        mb5_reg     <= mb5_next;
        dst5_reg    <= src.dst;
        written_reg <= written_next;
        pixel_reg   <= pixel_next;
    end

    assign done      = done_reg;
    assign pixel_out = pixel_reg;
    assign written   = written_reg;

endmodule

/* src/coverage_source_over_blend_unit.sv */
// Channel   Direction  Signals                                 Request taken when
// pixel     in         start, coverage, mask_sample, dst_pixel start && !busy
// result    out        done, pixel_out, written                done (one cycle)
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// Stages 0 to 6 lie between start and done; one pixel per clock.
// busy and cfg_ready are constant; the pipeline never holds a request.
// Reset clears the pipeline valid bits and loads the register defaults.
// Results cannot be stalled; done marks each one for a single cycle.
module coverage_source_over_blend_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [csob_pkg::CovW-1:0]     coverage,
    input  logic [csob_pkg::CovW-1:0]     mask_sample,
    input  logic [csob_pkg::PixW-1:0]     dst_pixel,
    output logic                          done,
    output logic [csob_pkg::PixW-1:0]     pixel_out,
    output logic                          written,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [csob_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [csob_pkg::CovW-1:0]     cfg_data
);
    import csob_pkg::*;

    cfg_t cfg;
    src_t src;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    csob_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    csob_src u_src (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .coverage    (coverage),
        .mask_sample (mask_sample),
        .dst_pixel   (dst_pixel),
        .cfg         (cfg),
        .src         (src)
    );

    csob_over u_over (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (src),
        .done      (done),
        .pixel_out (pixel_out),
        .written   (written)
    );

endmodule
